### rtl/amo_pkg.sv
`timescale 1ns / 1ps
// Shared constants, S-box table and AES round helper functions for the MMO block.
// No dependencies; imported by every module of the block.
package amo_pkg;

  localparam int ROUNDS = 10;
  localparam int CNT_W = $clog2(ROUNDS + 1);

  // Register indexes of the configuration port.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef logic [127:0] blk_t;
  typedef logic [ROUNDS:0][127:0] rk_set_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows; byte i of the state is row i%4, column i/4.
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        t[8*(row+4*col) +: 8] = SBOX[s[8*(row+4*((col+row)%4)) +: 8]];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[8*(4*c) +: 8];
      a1 = s[8*(4*c+1) +: 8];
      a2 = s[8*(4*c+2) +: 8];
      a3 = s[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[8*(4*c) +: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
      t[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

### rtl/amo_round.sv
`timescale 1ns / 1ps
// One AES round datapath: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on amo_pkg.
module amo_round
  import amo_pkg::*;
#(
  parameter bit LAST = 1'b0
) (
  input  blk_t state,
  input  blk_t round_key,
  output blk_t result
);

  blk_t ss;

  assign ss = sub_shift(state);

  generate
    if (LAST) begin : g_last
      assign result = ss ^ round_key;
    end else begin : g_mid
      assign result = mix_columns(ss) ^ round_key;
    end
  endgenerate

endmodule

### rtl/amo_key_exp.sv
`timescale 1ns / 1ps
// Key registers and a sequential AES-128 key schedule, one round key per cycle.
// Depends on amo_pkg.
module amo_key_exp
  import amo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output rk_set_t     round_keys,
  output logic        busy
);

  logic [63:0]      key_low;
  logic [63:0]      key_high;
  blk_t             cur;
  blk_t             cur_next;
  logic [7:0]       rcon;
  logic [CNT_W-1:0] cnt;
  blk_t             store [1:ROUNDS];
  logic [7:0]       t0, t1, t2, t3;

  always_comb begin
    t0 = SBOX[cur[8*13 +: 8]] ^ rcon;
    t1 = SBOX[cur[8*14 +: 8]];
    t2 = SBOX[cur[8*15 +: 8]];
    t3 = SBOX[cur[8*12 +: 8]];
    cur_next[31:0] = cur[31:0] ^ {t3, t2, t1, t0};
    for (int w = 1; w < 4; w++) begin
      cur_next[32*w +: 32] = cur[32*w +: 32] ^ cur_next[32*(w-1) +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      cur      <= '0;
      rcon     <= 8'h01;
      cnt      <= CNT_W'(1);
      busy     <= 1'b1;
    end else if (cfg_we) begin
      // Any write restarts the schedule from the updated key.
      unique case (cfg_index)
        REG_KEY_LOW: begin
          key_low <= cfg_data;
          cur     <= {key_high, cfg_data};
        end
        REG_KEY_HIGH: begin
          key_high <= cfg_data;
          cur      <= {cfg_data, key_low};
        end
        default: ;
      endcase
      rcon <= 8'h01;
      cnt  <= CNT_W'(1);
      busy <= 1'b1;
    end else if (busy) begin
      cur  <= cur_next;
      rcon <= xtime(rcon);
      cnt  <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(ROUNDS)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !cfg_we) begin
      store[cnt] <= cur_next;
    end
  end

  always_comb begin
    round_keys[0] = {key_high, key_low};
    for (int r = 1; r <= ROUNDS; r++) begin
      round_keys[r] = store[r];
    end
  end

endmodule

### rtl/aes128_mmo_prg_block.sv
`timescale 1ns / 1ps
// Top level of the AES-128 Matyas-Meyer-Oseas step; uses amo_pkg, amo_key_exp and
// amo_round.
//
// Each input beat carries one 128-bit block X (byte 0 in bits 7:0 of block_low) and
// produces one output beat E_K(X) XOR X in the same byte order. The cipher is an
// eleven-stage pipeline: stage 0 applies the initial round key and stages 1 to 10
// each hold one AES round, the last of which also folds in X and acts as the output
// register. One beat is accepted per cycle while in_ready is high, and each beat
// passes through stages 0 to 10 in order. Each stage advances when it is empty or its
// successor moves, so stalls at the output collapse bubbles and nothing is lost or
// repeated. The key is written through the plain write port (index 0 for key bytes
// 0 to 7, index 1 for bytes 8 to 15). Each write, and reset, starts the key
// schedule, which produces one round key per cycle; in_ready stays low until it ends.
// Keys may only be changed while the pipeline is empty.
module aes128_mmo_prg_block
  import amo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_low,
  output logic [63:0] out_high
);

  rk_set_t           round_keys;
  logic              key_busy;
  logic [ROUNDS:0]   vld;
  logic [ROUNDS+1:0] take;
  blk_t              st  [0:ROUNDS];
  blk_t              xin [0:ROUNDS-1];
  blk_t              rnd [1:ROUNDS];

  amo_key_exp u_key (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys),
    .busy       (key_busy)
  );

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    take[ROUNDS+1] = out_ready;
    for (int k = 0; k <= ROUNDS; k++) begin
      take[k] = !vld[k] || take[k+1];
    end
  end

  assign in_ready = take[0] && !key_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (take[0]) begin
      vld[0] <= in_valid && !key_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      st[0]  <= {block_high, block_low} ^ round_keys[0];
      xin[0] <= {block_high, block_low};
    end
  end

  genvar g;
  generate
    for (g = 1; g <= ROUNDS; g++) begin : g_stage
      amo_round #(.LAST(g == ROUNDS)) u_round (
        .state     (st[g-1]),
        .round_key (round_keys[g]),
        .result    (rnd[g])
      );

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[g] <= 1'b0;
        end else if (take[g]) begin
          vld[g] <= vld[g-1];
        end
      end

      if (g == ROUNDS) begin : g_out
        // The final stage applies the feed-forward XOR with the original block.
        always_ff @(posedge clk) begin
          if (take[g]) begin
            st[g] <= rnd[g] ^ xin[g-1];
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (take[g]) begin
            st[g]  <= rnd[g];
            xin[g] <= xin[g-1];
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[ROUNDS];
  assign out_low   = st[ROUNDS][63:0];
  assign out_high  = st[ROUNDS][127:64];

endmodule
